// ===== rtl/lzw12_pkg.sv =====
// ----------------------------------------------------------------------------
// lzw12_pkg
// Shared types and constants of the 12-bit LZW stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzw12_pkg;

  localparam int CODE_W   = 12;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 24;
  localparam int PEND_W   = 13;
  localparam int STATUS_W = 2;

  // stream port widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CODE_W-1:0] END_CODE   = 12'd4095;
  localparam logic [CODE_W-1:0] FIRST_FREE = 12'd256;

  // input item kinds (tuser)
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // run_state codes
  localparam logic [STATUS_W-1:0] RUN_BUSY   = 2'd0;
  localparam logic [STATUS_W-1:0] RUN_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] RUN_FAIL   = 2'd2;
  localparam logic [STATUS_W-1:0] RUN_REJECT = 2'd3;

  // dictionary write request
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
  } tbl_wr_t;

  // pending stack write request
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } stk_wr_t;

endpackage

`default_nettype wire

// ===== rtl/lzw12_table.sv =====
// ----------------------------------------------------------------------------
// lzw12_table
// Dictionary memory: prefix code and suffix byte per entry, one write port,
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_table #(
  parameter int DEPTH = 4096
) (
  input  wire logic                               clk,
  input  wire lzw12_pkg::tbl_wr_t                 wr,
  input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic      [lzw12_pkg::CODE_W-1:0]       rd_prefix,
  output logic      [lzw12_pkg::BYTE_W-1:0]       rd_suffix
);
  import lzw12_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CODE_W+BYTE_W-1:0] mem [DEPTH];
  logic [CODE_W+BYTE_W-1:0] rd_q;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= {wr.prefix, wr.suffix};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  assign rd_prefix = rd_q[CODE_W+BYTE_W-1:BYTE_W];
  assign rd_suffix = rd_q[BYTE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/lzw12_stack.sv =====
// ----------------------------------------------------------------------------
// lzw12_stack
// Pending output byte stack: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_stack #(
  parameter int DEPTH = 4096
) (
  input  wire logic                               clk,
  input  wire lzw12_pkg::stk_wr_t                 wr,
  input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic      [lzw12_pkg::BYTE_W-1:0]       rd_data
);
  import lzw12_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/lzw12_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// lzw12_stream_decoder_top
// 12-bit fixed-width LZW decoder with a byte-wide input stream and a
// per-tick drained output.
// ----------------------------------------------------------------------------
// Each input transaction is either a compressed byte (tuser 0) or a drain
// tick (tuser 1), and each yields exactly one result transaction. A tick,
// a push that does not complete a code, a rejected push, the first code and
// the end code need no chain walk. A push that completes any other code
// walks the prefix chain through the dictionary read port, one chain step
// per cycle; when the code is not yet in the dictionary, the repeated first
// byte needs no chain step, and a bad chain ends the walk early.
// The output register adds waiting only while the result side stalls.
// The dictionary needs no clearing pass after reset: entries at or above the
// next free code read as zero, so the block is ready right after reset.
// The user writes expected_length on the cfg channel only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module lzw12_stream_decoder_top #(
  parameter int TABLE_SIZE = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [lzw12_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] compressed_byte
  input  wire logic                                s_tuser,   // [0] action
  input  wire logic                                s_tlast,   // is_last_byte
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [lzw12_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] decoded_byte,
                                                              // [9:8] run_state,
                                                              // [22:10] pending_left
  output logic                                     m_tuser,   // [0] byte_valid
  // configuration write
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lzw12_pkg::LEN_W-1:0]         cfg_data   // expected_length
);
  import lzw12_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int PW = AW + 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  // control state
  logic [1:0]          state;
  logic [STATUS_W-1:0] status;
  logic [PEND_W-1:0]   pending;
  logic [CODE_W-1:0]   nfc;
  logic [1:0]          phase;
  logic                first_seen;
  logic [LEN_W-1:0]    out_count;
  logic [LEN_W-1:0]    expected_len;

  // decode payload
  logic [CODE_W-1:0]   prev_code;
  logic [CODE_W-1:0]   code_q;
  logic [CODE_W-1:0]   cur_code;
  logic [BYTE_W-1:0]   head_byte;
  logic [BYTE_W-1:0]   held;
  logic [PW-1:0]       pos;
  logic                base_one;
  logic                last_flag;

  // result holding
  logic                res_valid;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_reject;

  // memory ports
  tbl_wr_t             tbl_wr;
  stk_wr_t             stk_wr;
  logic [AW-1:0]       tbl_rd_addr;
  logic [CODE_W-1:0]   tbl_prefix;
  logic [BYTE_W-1:0]   tbl_suffix;
  logic [AW-1:0]       stk_rd_addr;
  logic [BYTE_W-1:0]   stk_q;
  logic [PEND_W-1:0]   pend_m1;

  // datapath
  logic                accept;
  logic                out_free;
  logic                have;
  logic [CODE_W-1:0]   in_code;
  logic                kwk;
  logic [CODE_W-1:0]   start_code;
  logic [CODE_W-1:0]   pfx_eff;
  logic [BYTE_W-1:0]   sfx_eff;
  logic                walk_lit;
  logic                walk_bad;
  logic                pos_full;
  logic [PW-1:0]       walk_len;
  logic [LEN_W-1:0]    room;
  logic                len_over;
  logic                tbl_room;
  logic                lit_ok;
  logic [STATUS_W-1:0] run_state;

  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // code assembly: two codes per three bytes, low nibble first
  assign have    = (phase == 2'd1) || (phase == 2'd2);
  assign in_code = (phase == 2'd1) ? {s_tdata[3:0], held} : {s_tdata, held[7:4]};
  assign kwk     = (in_code >= nfc);
  assign start_code = kwk ? prev_code : in_code;

  // dictionary entries not yet written read as zero
  assign pfx_eff = (cur_code >= nfc) ? '0 : tbl_prefix;
  assign sfx_eff = (cur_code >= nfc) ? '0 : tbl_suffix;

  // chain walk checks
  assign walk_lit = (cur_code[CODE_W-1:BYTE_W] == '0);
  assign pos_full = (pos >= PW'(TABLE_SIZE));
  assign walk_bad = (cur_code >= END_CODE)
                 || ({1'b0, cur_code} >= (CODE_W+1)'(TABLE_SIZE))
                 || ((pos - PW'(base_one)) >= PW'(TABLE_SIZE - 1))
                 || pos_full;
  assign walk_len = pos + PW'(1);
  assign room     = expected_len - out_count;
  assign len_over = (LEN_W'(walk_len) > room);
  assign tbl_room = (nfc < END_CODE) && ({1'b0, nfc} < (CODE_W+1)'(TABLE_SIZE));
  assign lit_ok   = (state == ST_WALK) && walk_lit && !pos_full && !len_over;

  // dictionary read address: walk start, then follow the prefix
  always_comb begin
    if (state == ST_WALK) begin
      tbl_rd_addr = pfx_eff[AW-1:0];
    end else begin
      tbl_rd_addr = start_code[AW-1:0];
    end
  end

  // dictionary update once a string is complete
  always_comb begin
    tbl_wr.en     = lit_ok && tbl_room;
    tbl_wr.addr   = nfc;
    tbl_wr.prefix = prev_code;
    tbl_wr.suffix = cur_code[BYTE_W-1:0];
  end

  // stack writes: first literal, repeated first byte, chain bytes
  always_comb begin
    stk_wr.en   = 1'b0;
    stk_wr.addr = '0;
    stk_wr.data = '0;
    if (accept && s_tuser == ACT_PUSH && status == RUN_BUSY && pending == '0 && have) begin
      if (!first_seen) begin
        stk_wr.en   = 1'b1;
        stk_wr.data = in_code[BYTE_W-1:0];
      end else if (in_code != END_CODE && kwk) begin
        stk_wr.en   = 1'b1;
        stk_wr.data = head_byte;
      end
    end else if (state == ST_WALK) begin
      stk_wr.addr = CODE_W'(pos[AW-1:0]);
      if (!walk_lit) begin
        stk_wr.en   = !walk_bad;
        stk_wr.data = sfx_eff;
      end else begin
        stk_wr.en   = !pos_full;
        stk_wr.data = cur_code[BYTE_W-1:0];
      end
    end
  end

  // top of stack is always being read
  assign pend_m1     = pending - PEND_W'(1);
  assign stk_rd_addr = pend_m1[AW-1:0];

  lzw12_table #(.DEPTH(TABLE_SIZE)) u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .rd_addr   (tbl_rd_addr),
    .rd_prefix (tbl_prefix),
    .rd_suffix (tbl_suffix)
  );

  lzw12_stack #(.DEPTH(TABLE_SIZE)) u_stack (
    .clk     (clk),
    .wr      (stk_wr),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      status       <= RUN_BUSY;
      pending      <= '0;
      nfc          <= FIRST_FREE;
      phase        <= '0;
      first_seen   <= 1'b0;
      out_count    <= '0;
      expected_len <= '0;
      prev_code    <= '0;
      head_byte    <= '0;
      held         <= '0;
      code_q       <= '0;
      cur_code     <= '0;
      pos          <= '0;
      base_one     <= 1'b0;
      last_flag    <= 1'b0;
      res_valid    <= 1'b0;
      res_byte     <= '0;
      res_reject   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        expected_len <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_valid  <= 1'b0;
            res_byte   <= '0;
            res_reject <= 1'b0;
            state      <= ST_RESULT;
            if (s_tuser == ACT_TICK) begin
              // drain one byte from the top of the stack
              if (pending != '0) begin
                pending   <= pend_m1;
                res_valid <= 1'b1;
                res_byte  <= stk_q;
              end
            end else if (status != RUN_BUSY || pending != '0) begin
              res_reject <= 1'b1;
            end else if (!have) begin
              held  <= s_tdata;
              phase <= 2'd1;
              if (s_tlast) begin
                status <= RUN_FAIL;
              end
            end else begin
              if (phase == 2'd1) begin
                held  <= s_tdata;
                phase <= 2'd2;
              end else begin
                phase <= 2'd0;
              end
              if (!first_seen) begin
                // first code must be a literal
                if (in_code[CODE_W-1:BYTE_W] != '0 || out_count >= expected_len) begin
                  status <= RUN_FAIL;
                end else begin
                  pending    <= PEND_W'(1);
                  out_count  <= LEN_W'(1);
                  head_byte  <= in_code[BYTE_W-1:0];
                  prev_code  <= in_code;
                  first_seen <= 1'b1;
                  if (s_tlast) begin
                    status  <= RUN_FAIL;
                    pending <= '0;
                  end
                end
              end else if (in_code == END_CODE) begin
                status <= (out_count == expected_len) ? RUN_DONE : RUN_FAIL;
              end else begin
                // start the chain walk
                cur_code  <= start_code;
                code_q    <= in_code;
                last_flag <= s_tlast;
                base_one  <= kwk;
                pos       <= kwk ? PW'(1) : '0;
                state     <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          if (!walk_lit) begin
            if (walk_bad) begin
              status <= RUN_FAIL;
              state  <= ST_RESULT;
            end else begin
              pos      <= pos + PW'(1);
              cur_code <= pfx_eff;
            end
          end else begin
            state <= ST_RESULT;
            if (pos_full || len_over) begin
              status <= RUN_FAIL;
            end else begin
              head_byte  <= cur_code[BYTE_W-1:0];
              pending    <= PEND_W'(walk_len);
              out_count  <= out_count + LEN_W'(walk_len);
              prev_code  <= code_q;
              if (tbl_room) begin
                nfc <= nfc + CODE_W'(1);
              end
              if (last_flag) begin
                status  <= RUN_FAIL;
                pending <= '0;
              end
            end
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign run_state = res_reject ? RUN_REJECT : status;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {1'b0, pending, run_state, res_byte};
      m_tuser  <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // stack never holds more than its depth
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(TABLE_SIZE))
    else $error("pending count above stack depth");

  // a failed run keeps nothing queued
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (status == RUN_FAIL) |-> (pending == '0))
    else $error("bytes pending after failure");

  // next free code only grows and stays within the table
  a_nfc_grow: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (nfc >= $past(nfc) && nfc <= END_CODE))
    else $error("next free code moved backwards or past the end code");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input accepted while an item is in flight");

endmodule

`default_nettype wire
